>>> hw/rtl/tdp_pkg.sv
// Shared constants and controller/datapath interface structs for the
// trial division prime test. No dependencies.
package tdp_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int FIRST_DIVISOR   = 2;

  typedef struct packed {
    logic load_n;
    logic init_d;
    logic next_d;
    logic div_start;
    logic finish;
    logic prime;
  } tdp_cmd_t;

  typedef struct packed {
    logic below_two;
    logic in_range;
    logic rem_done;
    logic rem_zero;
  } tdp_status_t;

endpackage

>>> hw/rtl/trial_division_prime_test.sv
// Candidates below 2 go straight to a result; otherwise each divisor tried,
// from 2 up to the smallest factor or past the square root, takes one pass
// through the bit-serial remainder unit, so the time to a result grows with
// the number of divisors tried.
// One word in flight; the next is taken in the cycle after the result is registered,
// also while that result waits.
// Reset (rst, synchronous) clears controller state and output valid.
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tdp_pkg::FIELD_WIDTH-1:0] candidate,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tdp_pkg::FIELD_WIDTH-1:0] tested_value,
  output logic                            is_prime
);
  import tdp_pkg::*;

  tdp_cmd_t    cmd;
  tdp_status_t status;

  tdp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tdp_dp #(.WIDTH(VALUE_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .candidate    (candidate),
    .tested_value (tested_value),
    .is_prime     (is_prime)
  );

endmodule

>>> hw/rtl/tdp_rem.sv
// Serial remainder unit: one restoring step per cycle, WIDTH steps per
// remainder. Depends on nothing.
module tdp_rem #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] shift;
  logic [WIDTH-1:0] rem;
  logic [CW-1:0]    count;
  logic             busy;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem, shift[WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
      count <= CW'(WIDTH - 1);
    end else if (busy) begin
      shift <= {shift[WIDTH-2:0], 1'b0};
      count <= count - 1'b1;
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
      end else begin
        rem <= trial[WIDTH-1:0];
      end
    end
  end

  assign remainder = rem;

endmodule

>>> hw/rtl/tdp_dp.sv
// Datapath: held candidate, trial divisor and its square, remainder unit,
// result payload. Depends on tdp_pkg and tdp_rem.
module tdp_dp #(
  parameter int WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tdp_pkg::tdp_cmd_t                cmd,
  output tdp_pkg::tdp_status_t             status,
  input  logic [tdp_pkg::FIELD_WIDTH-1:0]  candidate,
  output logic [tdp_pkg::FIELD_WIDTH-1:0]  tested_value,
  output logic                             is_prime
);
  import tdp_pkg::*;

  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] d;
  logic [WIDTH+1:0] sq;
  logic             rem_done;
  logic [WIDTH-1:0] rem;

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n <= WIDTH'(candidate);
    end
    if (cmd.init_d) begin
      d  <= WIDTH'(FIRST_DIVISOR);
      sq <= (WIDTH+2)'(FIRST_DIVISOR * FIRST_DIVISOR);
    end else if (cmd.next_d) begin
      d  <= d + 1'b1;
      sq <= sq + {1'b0, d, 1'b1};
    end
    if (cmd.finish) begin
      tested_value <= FIELD_WIDTH'(n);
      is_prime     <= cmd.prime;
    end
  end

  tdp_rem #(.WIDTH(WIDTH)) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (n),
    .divisor   (d),
    .done      (rem_done),
    .remainder (rem)
  );

  always_comb begin
    status.below_two = (n[WIDTH-1:1] == '0);
    status.in_range  = (sq <= {2'b00, n});
    status.rem_done  = rem_done;
    status.rem_zero  = (rem == '0);
  end

endmodule

>>> hw/rtl/tdp_ctrl.sv
// Controller: sequences the divisor search and owns both handshakes.
// Depends on tdp_pkg.
module tdp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tdp_pkg::tdp_status_t status,
  output tdp_pkg::tdp_cmd_t    cmd
);
  import tdp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       verdict;
  logic       verdict_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    verdict_next   = verdict;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.prime      = verdict;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_n = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (status.below_two) begin
          verdict_next = 1'b0;
          state_next   = S_DONE;
        end else begin
          cmd.init_d = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.in_range) begin
          verdict_next = 1'b1;
          state_next   = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (status.rem_done) begin
          if (status.rem_zero) begin
            verdict_next = 1'b0;
            state_next   = S_DONE;
          end else begin
            cmd.next_d = 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      verdict   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      verdict   <= verdict_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> tb/prime_checker.sv
// Scoreboard for trial_division_prime_test: watches both channels, predicts
// the primality verdict of each accepted word and compares results in order.
// Depends on tdp_pkg for the field width and the first divisor.
`timescale 1ns / 100ps

module prime_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [tdp_pkg::FIELD_WIDTH-1:0] candidate,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [tdp_pkg::FIELD_WIDTH-1:0] tested_value,
  input  logic                            is_prime,
  output int                              errors,
  output int                              pending
);
  import tdp_pkg::*;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] value;
    logic                   prime;
  } verdict_t;

  verdict_t verdicts[$];

  function automatic logic prime_flag(input logic [FIELD_WIDTH-1:0] value);
    longint unsigned n;
    longint unsigned d;
    n = value;
    if (n < FIRST_DIVISOR) return 1'b0;
    for (d = FIRST_DIVISOR; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      errors  = 0;
      pending = 0;
      verdicts.delete();
    end else begin
      if (in_valid && !in_stall) begin
        verdicts.push_back('{value: candidate, prime: prime_flag(candidate)});
      end
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected word, expected none, got value %h prime %b",
                   $time, tested_value, is_prime);
          errors++;
        end else begin
          want = verdicts.pop_front();
          if (tested_value !== want.value) begin
            $display("%0t: tested_value mismatch, expected %h, got %h",
                     $time, want.value, tested_value);
            errors++;
          end
          if (is_prime !== want.prime) begin
            $display("%0t: is_prime mismatch for %0d, expected %b, got %b",
                     $time, want.value, want.prime, is_prime);
            errors++;
          end
        end
      end
      pending = verdicts.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the trial_division_prime_test bench: clock, reset, candidate stimulus
// and result back-pressure. Checking lives in prime_checker; needs tdp_pkg.
`timescale 1ns / 100ps

module testbench;
  import tdp_pkg::*;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [FIELD_WIDTH-1:0] candidate = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [FIELD_WIDTH-1:0] tested_value;
  logic                   is_prime;

  int fail_count;
  int open_words;
  int words_sent = 0;

  int small_primes[] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                         53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  trial_division_prime_test u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .candidate    (candidate),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tested_value (tested_value),
    .is_prime     (is_prime)
  );

  prime_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .candidate    (candidate),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tested_value (tested_value),
    .is_prime     (is_prime),
    .errors       (fail_count),
    .pending      (open_words)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Big values get a forced small factor, since a large prime would need
  // a remainder for every divisor up to its square root.
  function automatic logic [FIELD_WIDTH-1:0] pick_candidate(input bit squeeze);
    logic [FIELD_WIDTH-1:0] value;
    int roll;
    int factor;
    roll = $urandom_range(0, 99);
    if (squeeze) return $urandom_range(0, 255);
    if (roll < 55) return $urandom_range(0, 4095);
    if (roll < 75) return $urandom_range(0, 65535);
    factor = small_primes[$urandom_range(0, small_primes.size() - 1)];
    value  = $urandom;
    return value - (value % factor);
  endfunction

  task automatic offer_word(input logic [FIELD_WIDTH-1:0] value, input bit no_gap);
    int gap;
    int roll;
    in_valid  <= 1'b1;
    candidate <= value;
    do @(posedge clk); while (in_stall);
    words_sent++;
    roll = $urandom_range(0, 99);
    if (no_gap || roll < 45) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side; one long hold-off once the input has been running a while.
  initial begin
    int roll;
    int span;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && words_sent >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 20);
        end else if (roll < 95) begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          span = $urandom_range(20, 60);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin
    logic [FIELD_WIDTH-1:0] corners[$];
    bit squeeze;
    corners = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8,
                32'd9, 32'd25, 32'd49, 32'd97, 32'd121, 32'd65521, 32'd63001,
                32'd1048573, 32'd1042441, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (corners[i]) offer_word(corners[i], 1'b0);

    // Random words, with a run of back-to-back small words around the result-side hold-off.
    for (int i = 0; i < 76; i++) begin
      squeeze = (words_sent >= 55 && words_sent < 75);
      offer_word(pick_candidate(squeeze), squeeze);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (open_words == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> trial_division_prime_test.f
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_rem.sv
hw/rtl/tdp_dp.sv
hw/rtl/tdp_ctrl.sv
hw/rtl/trial_division_prime_test.sv
tb/prime_checker.sv
tb/testbench.sv
